[src/assert_macros.svh]
// Assertion helpers; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FRAC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frac assertion failed");

// Next-cycle implication, checked out of reset.
`define FRAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frac assertion failed");

`endif

[src/frac_pkg.sv]
package frac_pkg;

  localparam int OP_W        = 3;
  localparam int REG_FIELD_W = 4;
  localparam int OPERAND_W   = 16;
  localparam int WORD_W      = 64;
  localparam int HALF_W      = 32;

  // Instruction codes; anything else is ignored.
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
  localparam logic [OP_W-1:0] OP_STORE = 3'd1;
  localparam logic [OP_W-1:0] OP_INC   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEC   = 3'd3;
  localparam logic [OP_W-1:0] OP_JNZ   = 3'd4;
  localparam logic [OP_W-1:0] OP_MUL   = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [REG_FIELD_W-1:0] reg_a;
    logic [REG_FIELD_W-1:0] reg_b;
    logic [OPERAND_W-1:0]   operand;
    logic [WORD_W-1:0]      read_data;
  } instr_t;

  typedef struct packed {
    logic              start;
    logic              ack;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] product;
  } mul_rsp_t;

endpackage

[src/frac_ram.sv]
module frac_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]                      rd_data_a,
  output logic [WIDTH-1:0]                      rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

[src/frac_mul.sv]
module frac_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  frac_pkg::mul_req_t req,
  output frac_pkg::mul_rsp_t rsp
);

  import frac_pkg::*;

  typedef enum logic [3:0] {
    MS_IDLE     = 4'b0001,
    MS_CROSS_LH = 4'b0010,
    MS_CROSS_HL = 4'b0100,
    MS_SUM      = 4'b1000
  } mul_state_t;

  mul_state_t          state_r, state_nxt;
  logic [WORD_W-1:0]   prod_r, prod_nxt;
  logic [WORD_W-1:0]   acc_r, acc_nxt;
  logic [HALF_W-1:0]   mul_x, mul_y;
  logic [WORD_W-1:0]   mul_p;
  logic [HALF_W-1:0]   acc_hi_sum;

  // One 32x32 multiplier, shared over the three partial products.
  always_comb begin
    mul_x = req.a[HALF_W-1:0];
    mul_y = req.b[HALF_W-1:0];
    unique case (state_r)
      MS_IDLE:     ;
      MS_CROSS_LH: mul_y = req.b[WORD_W-1:HALF_W];
      MS_CROSS_HL: mul_x = req.a[WORD_W-1:HALF_W];
      MS_SUM:      ;
      default:     ;
    endcase
    mul_p = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};
  end

  assign acc_hi_sum = acc_r[WORD_W-1:HALF_W] + prod_r[HALF_W-1:0];

  always_comb begin
    state_nxt = state_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    unique case (state_r)
      MS_IDLE: begin
        if (req.start) begin
          prod_nxt  = mul_p;
          state_nxt = MS_CROSS_LH;
        end
      end
      MS_CROSS_LH: begin
        acc_nxt   = prod_r;
        prod_nxt  = mul_p;
        state_nxt = MS_CROSS_HL;
      end
      MS_CROSS_HL: begin
        acc_nxt   = {acc_hi_sum, acc_r[HALF_W-1:0]};
        prod_nxt  = mul_p;
        state_nxt = MS_SUM;
      end
      MS_SUM: begin
        if (req.ack) begin
          state_nxt = MS_IDLE;
        end
      end
      default: state_nxt = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign rsp.done    = (state_r == MS_SUM);
  assign rsp.product = {acc_hi_sum, acc_r[HALF_W-1:0]};

endmodule

[src/frac_exec.sv]
module frac_exec #(
  parameter int NUM_REGS   = 4,
  parameter int PC_WIDTH   = 10,
  parameter int ADDR_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [frac_pkg::REG_FIELD_W-1:0]   rd_idx_a,
  input  logic [frac_pkg::REG_FIELD_W-1:0]   rd_idx_b,
  input  logic                               exec_valid,
  input  frac_pkg::instr_t                   instr,
  input  logic                               retire,
  input  frac_pkg::mul_rsp_t                 mul_rsp,
  output frac_pkg::mul_req_t                 mul_req,
  output logic                               res_ready,
  output logic [PC_WIDTH-1:0]                res_next_pc,
  output logic                               res_write_enable,
  output logic [frac_pkg::OPERAND_W-1:0]     res_write_address,
  output logic [frac_pkg::WORD_W-1:0]        res_write_data,
  output logic                               res_took_effect,
  output logic                               res_flag
);

  import frac_pkg::*;

  localparam int IDX_W = $clog2(NUM_REGS);
  localparam int SLOTS = 1 << IDX_W;
  localparam logic [OPERAND_W-1:0] ADDR_MASK = (ADDR_WIDTH >= OPERAND_W) ? '1 :
      OPERAND_W'((33'd1 << ADDR_WIDTH) - 33'd1);

  logic [SLOTS-1:0]    valid_r;
  logic [IDX_W-1:0]    ridx_a, ridx_b, wr_idx;
  logic                wr_en;
  logic [WORD_W-1:0]   wr_val;
  logic                wr_reg;
  logic [WORD_W-1:0]   rdata_a, rdata_b;
  logic                vld_a_r, vld_b_r, byp_a_r, byp_b_r;
  logic [WORD_W-1:0]   byp_data_r;
  logic                hit_a, hit_b;
  logic [WORD_W-1:0]   op_a, op_b;
  logic [PC_WIDTH-1:0] pc_r, pc_nxt, pc_inc, npc;
  logic                flag_r, flag_nxt;
  logic                ra_ok, rb_ok, done, jump, mul_need;
  logic [WORD_W-1:0]   sum_inc, sum_dec;

  assign ridx_a = rd_idx_a[IDX_W-1:0];
  assign ridx_b = rd_idx_b[IDX_W-1:0];
  assign wr_idx = instr.reg_a[IDX_W-1:0];
  assign wr_en  = retire && wr_reg;
  assign hit_a  = wr_en && (wr_idx == ridx_a);
  assign hit_b  = wr_en && (wr_idx == ridx_b);

  frac_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_regs (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_idx),
    .wr_data   (wr_val),
    .rd_addr_a (ridx_a),
    .rd_addr_b (ridx_b),
    .rd_data_a (rdata_a),
    .rd_data_b (rdata_b)
  );

  // Entries never written read as zero; a same-edge write is bypassed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      byp_a_r <= 1'b0;
      byp_b_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      vld_a_r <= valid_r[ridx_a] || hit_a;
      vld_b_r <= valid_r[ridx_b] || hit_b;
      byp_a_r <= hit_a;
      byp_b_r <= hit_b;
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= wr_val;
  end

  assign op_a = !vld_a_r ? '0 : (byp_a_r ? byp_data_r : rdata_a);
  assign op_b = !vld_b_r ? '0 : (byp_b_r ? byp_data_r : rdata_b);

  assign ra_ok   = instr.reg_a < REG_FIELD_W'(NUM_REGS);
  assign rb_ok   = instr.reg_b < REG_FIELD_W'(NUM_REGS);
  assign pc_inc  = pc_r + PC_WIDTH'(1);
  assign sum_inc = op_a + WORD_W'(1);
  assign sum_dec = op_a - WORD_W'(1);

  always_comb begin
    done              = 1'b0;
    jump              = 1'b0;
    mul_need          = 1'b0;
    wr_reg            = 1'b0;
    wr_val            = '0;
    flag_nxt          = flag_r;
    res_write_enable  = 1'b0;
    res_write_address = '0;
    res_write_data    = '0;
    unique case (instr.op)
      OP_LOAD: begin
        if (ra_ok) begin
          done   = 1'b1;
          wr_reg = 1'b1;
          wr_val = instr.read_data;
        end
      end
      OP_STORE: begin
        if (ra_ok) begin
          done              = 1'b1;
          res_write_enable  = 1'b1;
          res_write_address = instr.operand & ADDR_MASK;
          res_write_data    = op_a;
        end
      end
      OP_INC: begin
        if (ra_ok) begin
          done     = 1'b1;
          wr_reg   = 1'b1;
          wr_val   = sum_inc;
          flag_nxt = |sum_inc;
        end
      end
      OP_DEC: begin
        if (ra_ok) begin
          done     = 1'b1;
          wr_reg   = 1'b1;
          wr_val   = sum_dec;
          flag_nxt = |sum_dec;
        end
      end
      OP_JNZ: begin
        done = 1'b1;
        jump = flag_r;
      end
      OP_MUL: begin
        if (ra_ok && rb_ok) begin
          done     = 1'b1;
          mul_need = 1'b1;
          wr_reg   = 1'b1;
          wr_val   = mul_rsp.product;
        end
      end
      default: ;
    endcase
  end

  assign npc    = jump ? instr.operand[PC_WIDTH-1:0] : pc_inc;
  assign pc_nxt = (retire && done) ? npc : pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      flag_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (retire) begin
        flag_r <= flag_nxt;
      end
    end
  end

  assign mul_req.start = exec_valid && mul_need;
  assign mul_req.ack   = retire;
  assign mul_req.a     = op_a;
  assign mul_req.b     = op_b;

  assign res_ready       = !mul_need || mul_rsp.done;
  assign res_next_pc     = done ? npc : pc_r;
  assign res_took_effect = done;
  assign res_flag        = flag_nxt;

endmodule

[src/four_register_accumulator_cpu_step_top.sv]
// A request is registered into the execute stage on accept, then retires into the output register;
// a MUL with valid registers forms three 32x32 partial products on one multiplier.
// Throughput: one request per cycle while output is taken; a MUL holds execute until done.
// The next request may read a register written by the previous one without a bubble.
// Reset (rst_n low, synchronous): registers read as zero, PC and jump flag clear,
// pipeline and output valids drop. No clearing pass is needed.
module four_register_accumulator_cpu_step_top #(
  parameter int NUM_REGS   = 4,
  parameter int PC_WIDTH   = 10,
  parameter int ADDR_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [frac_pkg::OP_W-1:0]            in_operation,
  input  logic [frac_pkg::REG_FIELD_W-1:0]     in_reg_a,
  input  logic [frac_pkg::REG_FIELD_W-1:0]     in_reg_b,
  input  logic [frac_pkg::OPERAND_W-1:0]       in_operand_value,
  input  logic signed [frac_pkg::WORD_W-1:0]   in_read_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [PC_WIDTH-1:0]                  out_next_pc,
  output logic                                 out_write_enable,
  output logic [frac_pkg::OPERAND_W-1:0]       out_write_address,
  output logic signed [frac_pkg::WORD_W-1:0]   out_write_data,
  output logic                                 out_took_effect,
  output logic                                 out_nonzero_flag
);

  import frac_pkg::*;

`include "assert_macros.svh"

  // Execute stage: the registered request being worked on.
  logic                   e_valid_r, e_valid_nxt;
  instr_t                 e_instr_r;
  logic                   in_fire, retire;
  logic [REG_FIELD_W-1:0] rd_idx_a, rd_idx_b;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic [PC_WIDTH-1:0]    out_next_pc_r;
  logic                   out_we_r;
  logic [OPERAND_W-1:0]   out_waddr_r;
  logic [WORD_W-1:0]      out_wdata_r;
  logic                   out_done_r;
  logic                   out_flag_r;

  // Execute results.
  mul_req_t               mul_req;
  mul_rsp_t               mul_rsp;
  logic                   res_ready;
  logic [PC_WIDTH-1:0]    res_next_pc;
  logic                   res_write_enable;
  logic [OPERAND_W-1:0]   res_write_address;
  logic [WORD_W-1:0]      res_write_data;
  logic                   res_took_effect;
  logic                   res_flag;

  // Retire when the result is complete and the output register is free or draining.
  assign retire   = e_valid_r && res_ready && (!out_valid_r || out_ready);
  // Take a new request whenever the execute stage empties this cycle.
  assign in_ready = !e_valid_r || retire;
  assign in_fire  = in_valid && in_ready;

  // Register file read addresses: the incoming request on accept, otherwise hold.
  assign rd_idx_a = in_fire ? in_reg_a : e_instr_r.reg_a;
  assign rd_idx_b = in_fire ? in_reg_b : e_instr_r.reg_b;

  assign e_valid_nxt = in_fire ? 1'b1 : (retire ? 1'b0 : e_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else begin
      e_valid_r <= e_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      e_instr_r.op        <= in_operation;
      e_instr_r.reg_a     <= in_reg_a;
      e_instr_r.reg_b     <= in_reg_b;
      e_instr_r.operand   <= in_operand_value;
      e_instr_r.read_data <= $unsigned(in_read_data);
    end
  end

  frac_exec #(
    .NUM_REGS   (NUM_REGS),
    .PC_WIDTH   (PC_WIDTH),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_exec (
    .clk               (clk),
    .rst_n             (rst_n),
    .rd_idx_a          (rd_idx_a),
    .rd_idx_b          (rd_idx_b),
    .exec_valid        (e_valid_r),
    .instr             (e_instr_r),
    .retire            (retire),
    .mul_rsp           (mul_rsp),
    .mul_req           (mul_req),
    .res_ready         (res_ready),
    .res_next_pc       (res_next_pc),
    .res_write_enable  (res_write_enable),
    .res_write_address (res_write_address),
    .res_write_data    (res_write_data),
    .res_took_effect   (res_took_effect),
    .res_flag          (res_flag)
  );

  frac_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // Output register: load on retire, drop when taken.
  assign out_valid_nxt = retire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      out_next_pc_r <= res_next_pc;
      out_we_r      <= res_write_enable;
      out_waddr_r   <= res_write_address;
      out_wdata_r   <= res_write_data;
      out_done_r    <= res_took_effect;
      out_flag_r    <= res_flag;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_next_pc       = out_next_pc_r;
  assign out_write_enable  = out_we_r;
  assign out_write_address = out_waddr_r;
  assign out_write_data    = $signed(out_wdata_r);
  assign out_took_effect   = out_done_r;
  assign out_nonzero_flag  = out_flag_r;

  // A result without a memory write carries zero address and data.
  `FRAC_ASSERT_IMPL(a_no_write_zero, out_valid_r && !out_we_r,
                    (out_waddr_r == '0) && (out_wdata_r == '0))
  // Only an executed store writes memory.
  `FRAC_ASSERT_IMPL(a_write_took_effect, out_valid_r && out_we_r, out_done_r)
  // The multiplier only finishes for a MUL sitting in the execute stage.
  `FRAC_ASSERT_IMPL(a_mul_owner, mul_rsp.done, e_valid_r && (e_instr_r.op == OP_MUL))
  // A finished product is held until the MUL retires.
  `FRAC_ASSERT_NEXT(a_mul_hold, mul_rsp.done && !retire, mul_rsp.done)

endmodule
